// ----- design/i2a_pkg.sv -----
// Shared types, character codes and digit helpers for the integer-to-ASCII formatter.
// No dependencies.
`timescale 1ns / 1ps

package i2a_pkg;

  // Ten BCD digits cover the full 32-bit unsigned magnitude
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned BIN_WIDTH  = 32;

  typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;
  typedef logic [3:0]                 dig_idx_t;

  // Command codes
  localparam logic CMD_DEC = 1'b0;
  localparam logic CMD_HEX = 1'b1;

  // ASCII codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UPPER = 8'h41;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // Control from the sequencer to the conversion unit
  typedef struct packed {
    logic start;   // begin work on bin_in
    logic direct;  // hex: load nibbles as digits, no shifting
  } dab_cmd_t;

  // One digit value to its upper-case character
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d >= 4'd10) begin
      c = CH_UPPER + {4'h0, d - 4'd10};
    end else begin
      c = CH_ZERO + {4'h0, d};
    end
    return c;
  endfunction

endpackage

// ----- design/int_to_ascii_formatter_top.sv -----
// Top level of the integer-to-ASCII formatter: sequencer, leading-zero trim
// and output register. Depends on i2a_pkg and i2a_dabble.
`timescale 1ns / 1ps

//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  input   | in_valid, in_stall, cmd, value   | in  (in_stall out)
//  output  | out_valid, out_stall, char_out,  | out (out_stall in)
//          | last                             |
//
// Decimal: after acceptance the BCD unit shifts in the magnitude bit by bit, the
// trim state picks the top digit, then one character per cycle while out_stall
// allows. Hex loads the digits directly and skips the shifting.
// in_stall is high from acceptance until the last character is registered.
// out_stall holds the current character; the sequencer waits on it.
// Synchronous reset clears the sequencer and the output valid.

module int_to_ascii_formatter_top
  import i2a_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         char_out,
  output logic               last
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_TRIM = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t               state, state_next;
  dab_cmd_t             dab_cmd;
  logic                 dab_busy;
  bcd_t                 digits;
  logic                 in_acc;
  logic                 neg;
  logic [BIN_WIDTH-1:0] mag;
  logic                 sign_pend, pfx0_pend, pfxx_pend;
  dig_idx_t             dig_idx, top_idx;
  logic                 load, is_last;
  logic [7:0]           ch;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Sign and magnitude of the input
  assign neg = value[31];
  assign mag = neg ? (~value + 32'd1) : value;

  assign dab_cmd.start  = in_acc;
  assign dab_cmd.direct = (cmd == CMD_HEX);

  i2a_dabble u_dabble (
    .clk    (clk),
    .rst    (rst),
    .cmd_in (dab_cmd),
    .bin_in (mag),
    .busy   (dab_busy),
    .digits (digits)
  );

  // Highest nonzero digit; zero keeps one digit
  always_comb begin
    top_idx = '0;
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (digits[i] != 4'h0) begin
        top_idx = dig_idx_t'(i);
      end
    end
  end

  // Character selection for the next output
  assign load    = (state == S_EMIT) && (!out_valid || !out_stall);
  assign is_last = !sign_pend && !pfx0_pend && !pfxx_pend && (dig_idx == '0);

  always_comb begin
    if (sign_pend) begin
      ch = CH_MINUS;
    end else if (pfx0_pend) begin
      ch = CH_ZERO;
    end else if (pfxx_pend) begin
      ch = CH_X;
    end else begin
      ch = digit_char(digits[dig_idx]);
    end
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_acc) state_next = S_CONV;
      S_CONV: if (!dab_busy) state_next = S_TRIM;
      S_TRIM: state_next = S_EMIT;
      S_EMIT: if (load && is_last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Text position: pending prefix flags and digit index
  always_ff @(posedge clk) begin
    if (rst) begin
      sign_pend <= 1'b0;
      pfx0_pend <= 1'b0;
      pfxx_pend <= 1'b0;
      dig_idx   <= '0;
    end else if (in_acc) begin
      sign_pend <= neg;
      pfx0_pend <= (cmd == CMD_HEX);
      pfxx_pend <= (cmd == CMD_HEX);
    end else if (state == S_TRIM) begin
      dig_idx <= top_idx;
    end else if (load) begin
      if (sign_pend) begin
        sign_pend <= 1'b0;
      end else if (pfx0_pend) begin
        pfx0_pend <= 1'b0;
      end else if (pfxx_pend) begin
        pfxx_pend <= 1'b0;
      end else if (!is_last) begin
        dig_idx <= dig_idx - 1'b1;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      char_out <= ch;
      last     <= is_last;
    end
  end

endmodule

// ----- design/i2a_dabble.sv -----
// Iterative binary-to-BCD unit (shift and add-3), one bit per cycle.
// Depends on i2a_pkg. Also loads hex nibbles straight through.
`timescale 1ns / 1ps

module i2a_dabble
  import i2a_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  dab_cmd_t             cmd_in,
  input  logic [BIN_WIDTH-1:0] bin_in,
  output logic                 busy,
  output bcd_t                 digits
);

  localparam int unsigned CNT_W = $clog2(BIN_WIDTH + 1);

  logic [BIN_WIDTH-1:0] bin;
  logic [CNT_W-1:0]     cnt;
  bcd_t                 adj;

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (digits[i] >= 4'd5) ? digits[i] + 4'd3 : digits[i];
    end
  end

  // Control: counter and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (cmd_in.start) begin
      busy <= !cmd_in.direct;
      cnt  <= CNT_W'(BIN_WIDTH);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= (cnt != CNT_W'(1));
    end
  end

  // Datapath: digit and shift registers
  always_ff @(posedge clk) begin
    if (cmd_in.start) begin
      if (cmd_in.direct) begin
        digits <= bcd_t'({{(NUM_DIGITS * 4 - BIN_WIDTH){1'b0}}, bin_in});
      end else begin
        digits <= '0;
      end
      bin <= bin_in;
    end else if (busy) begin
      digits <= bcd_t'({adj[NUM_DIGITS-1:0] , bin[BIN_WIDTH-1]} >> 0)
                ;
      bin    <= {bin[BIN_WIDTH-2:0], 1'b0};
    end
  end

endmodule
